[hw/rtl/gpad_pkg.sv]
// ----------------------------------------------------------------------------
// gpad_pkg
// Shared types, constants and helpers for the Gaussian pair area difference.
// ----------------------------------------------------------------------------
package gpad_pkg;

  localparam int unsigned DIV_W = 40;

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [32:0] INV_SQRT2PI  = 33'd1713444047;
  localparam logic [7:0]  PC_RESET     = 8'd30;
  localparam logic [3:0]  EXP_TERMS    = 4'd12;
  localparam logic [6:0]  IT_SPAN      = 7'd36;
  localparam logic [6:0]  IT_COEF      = 7'd60;
  localparam logic [6:0]  IT_Z         = 7'd20;
  localparam logic [6:0]  IT_LN2       = 7'd8;
  localparam logic [6:0]  IT_FULL      = 7'd64;
  localparam logic [36:0] TERM_CAP     = 37'h10_0000_0000;
  localparam logic [47:0] VAR_CAP      = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RANGE, ST_ND, ST_NW, ST_CM, ST_CD, ST_CW, ST_PT, ST_ZW,
    ST_ZSQ, ST_QD, ST_QW, ST_H1, ST_H2, ST_H3, ST_EXP, ST_M, ST_C2, ST_C3,
    ST_TERM, ST_ITEM, ST_ACC, ST_MD, ST_MW, ST_MM, ST_VD, ST_VW, ST_SQ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       start;
    logic [6:0] iters;
  } div_ctl_t;

  // floor(2^32 / k) for the Horner divide-by-k steps
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

[hw/rtl/gpad_div.sv]
// ----------------------------------------------------------------------------
// gpad_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller sets the
// quotient length; the dividend shifted down by it must be below the divisor.
// ----------------------------------------------------------------------------
module gpad_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gpad_pkg::div_ctl_t        ctl_i,
  input  logic [63:0]               dividend_i,
  input  logic [gpad_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [63:0]               quo_o,
  output logic [gpad_pkg::DIV_W-1:0] rem_o
);
  import gpad_pkg::*;

  logic              busy_q, done_q;
  logic [6:0]        cnt_q;
  logic [DIV_W-1:0]  rem_q, dsr_q;
  logic [63:0]       lo_q, quo_q;
  logic [DIV_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, lo_q[63]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= DIV_W'(dividend_i >> ctl_i.iters);
      lo_q  <= dividend_i << (7'd64 - ctl_i.iters);
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
      lo_q  <= {lo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/gaussian_pair_area_difference.sv]
// Work: per point two density terms, each computed with divider and Horner
//   work on the shared multiplier (skipped when the point is 16 sigma or
//   more away), plus setup divides and, on a last beat, run statistics.
// Throughput: one beat at a time.
// Reset: async active low; sums and count clear, point_count returns to 30.
// ----------------------------------------------------------------------------
// gaussian_pair_area_difference
// Riemann sums of two Gaussian densities and their absolute difference, with
// run statistics of the difference; one multiplier and one divider shared.
// ----------------------------------------------------------------------------
module gaussian_pair_area_difference #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] mean_a_i,
  input  logic [31:0] sd_a_i,
  input  logic [31:0] mean_b_i,
  input  logic [31:0] sd_b_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] area_diff_o,
  output logic [31:0] area_a_o,
  output logic [31:0] area_b_o,
  output logic [31:0] err_mean_o,
  output logic [31:0] err_stddev_o,
  output logic        stats_valid_o
);
  import gpad_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W = 32 + CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  state_e state_q, state_d;

  logic [7:0]          pc_q, n_q;
  logic signed [31:0]  mean_a_q, mean_b_q;
  logic [31:0]         sd_a_q, sd_b_q;
  logic                last_q, sel_q;
  logic signed [37:0]  lo_q;
  logic [35:0]         span_q, qstep_q, qacc_q;
  logic [7:0]          rstep_q, racc_q, k_q;
  logic [59:0]         c_a_q, c_b_q;
  logic [19:0]         z_q;
  logic [31:0]         r_q, v_q;
  logic [4:0]          sh_q;
  logic [32:0]         p_q;
  logic [3:0]          hk_q;
  logic [30:0]         m_q;
  logic [62:0]         p1_q;
  logic [36:0]         t_q, ta_q;
  logic [44:0]         sum_d_q, sum_a_q, sum_b_q;
  logic [31:0]         ad_q, mean_o_q;
  logic [SUM_W-1:0]    err_sum_q;
  logic [63:0]         err_sq_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [47:0]         msq_q;
  logic [63:0]         sq_v_q, sq_res_q;
  logic [4:0]          sq_i_q;
  logic [65:0]         prod_q;
  logic                out_valid_q;
  logic [31:0]         o_diff_q, o_a_q, o_b_q, o_mean_q, o_sd_q;
  logic                o_stat_q;

  // shared units
  logic [32:0]      mul_a, mul_b;
  div_ctl_t         div_ctl;
  logic [63:0]      div_dvd, div_quo;
  logic [DIV_W-1:0] div_dsr, div_rem;
  logic             div_done;

  gpad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // item-level helpers
  logic signed [37:0] lo_a, lo_b, hi_a, hi_b, lo_w, hi_w, x_w, dd;
  logic [36:0]        u_w;
  logic               far_w;
  logic signed [31:0] mean_sel;
  logic [31:0]        sd_sel;
  logic [59:0]        c_sel;
  logic               out_free, in_acc;
  logic [CNT_W-1:0]   cnt_div;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign lo_a = 38'(mean_a_q) - $signed({4'b0, sd_a_q, 2'b0});
  assign lo_b = 38'(mean_b_q) - $signed({4'b0, sd_b_q, 2'b0});
  assign hi_a = 38'(mean_a_q) + $signed({4'b0, sd_a_q, 2'b0});
  assign hi_b = 38'(mean_b_q) + $signed({4'b0, sd_b_q, 2'b0});
  assign lo_w = (lo_a < lo_b) ? lo_a : lo_b;
  assign hi_w = (hi_a > hi_b) ? hi_a : hi_b;

  assign mean_sel = sel_q ? mean_b_q : mean_a_q;
  assign sd_sel   = sel_q ? sd_b_q : sd_a_q;
  assign c_sel    = sel_q ? c_b_q : c_a_q;
  assign x_w      = lo_q + $signed({2'b0, qacc_q});
  assign dd       = x_w - 38'(mean_sel);
  assign u_w      = dd[37] ? 37'(-dd) : dd[36:0];
  assign far_w    = u_w >= {1'b0, sd_sel, 4'b0};
  assign cnt_div  = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

  // Horner step correction
  logic [31:0] q0_w, qv_w;
  logic [35:0] rem_w;
  logic [63:0] var_w;
  logic [47:0] varc_w;
  logic [63:0] sq_bit, sq_sum;
  logic [63:0] p2_w;
  logic [36:0] s_w;

  assign q0_w   = prod_q[63:32];
  assign rem_w  = {4'b0, v_q} - 36'(q0_w * hk_q);
  assign qv_w   = q0_w + 32'(rem_w >= {32'b0, hk_q});
  assign var_w  = (div_quo > {16'b0, msq_q}) ? div_quo - {16'b0, msq_q} : 64'd0;
  assign varc_w = (var_w[63:48] != 16'd0) ? VAR_CAP : var_w[47:0];
  assign sq_bit = 64'd1 << {sq_i_q, 1'b0};
  assign sq_sum = sq_res_q + sq_bit;
  assign p2_w   = {5'b0, prod_q[58:0]};
  assign s_w    = {1'b0, p2_w[31:0], 4'b0} + {2'b0, p1_q[62:28]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    div_ctl = '0;
    div_dvd = '0;
    div_dsr = '0;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_RANGE;
      ST_RANGE: state_d = ST_ND;
      ST_ND: begin
        div_ctl = '{start: 1'b1, iters: IT_SPAN};
        div_dvd = {28'b0, span_q};
        div_dsr = DIV_W'(n_q);
        state_d = ST_NW;
      end
      ST_NW: if (div_done) state_d = ST_CM;
      ST_CM: begin
        mul_a   = {25'b0, n_q};
        mul_b   = {1'b0, sd_sel};
        state_d = ST_CD;
      end
      ST_CD: begin
        div_ctl = '{start: 1'b1, iters: IT_COEF};
        div_dvd = {4'b0, span_q, 24'b0};
        div_dsr = prod_q[DIV_W-1:0];
        state_d = ST_CW;
      end
      ST_CW: if (div_done) state_d = sel_q ? ST_PT : ST_CM;
      ST_PT: begin
        if (far_w) begin
          state_d = ST_TERM;
        end else begin
          div_ctl = '{start: 1'b1, iters: IT_Z};
          div_dvd = {11'b0, u_w, 16'b0};
          div_dsr = DIV_W'(sd_sel);
          state_d = ST_ZW;
        end
      end
      ST_ZW:  if (div_done) state_d = ST_ZSQ;
      ST_ZSQ: begin
        mul_a   = {13'b0, z_q};
        mul_b   = {13'b0, z_q};
        state_d = ST_QD;
      end
      ST_QD: begin
        div_ctl = '{start: 1'b1, iters: IT_LN2};
        div_dvd = {23'b0, prod_q[41:1]};
        div_dsr = DIV_W'(LN2_Q32);
        state_d = ST_QW;
      end
      ST_QW: if (div_done) state_d = (div_quo >= 64'd32) ? ST_TERM : ST_H1;
      ST_H1: begin
        mul_a   = {1'b0, r_q};
        mul_b   = p_q;
        state_d = ST_H2;
      end
      ST_H2: begin
        mul_a   = {1'b0, prod_q[63:32]};
        mul_b   = recip(hk_q);
        state_d = ST_H3;
      end
      ST_H3: state_d = (hk_q == 4'd1) ? ST_EXP : ST_H1;
      ST_EXP: begin
        mul_a   = p_q >> sh_q;
        mul_b   = INV_SQRT2PI;
        state_d = ST_M;
      end
      ST_M: begin
        mul_a   = {1'b0, c_sel[31:0]};
        mul_b   = {2'b0, prod_q[62:32]};
        state_d = ST_C2;
      end
      ST_C2: begin
        mul_a   = {5'b0, c_sel[59:32]};
        mul_b   = {2'b0, m_q};
        state_d = ST_C3;
      end
      ST_C3: state_d = ST_TERM;
      ST_TERM: begin
        if (!sel_q) state_d = ST_PT;
        else if ({1'b0, k_q} + 9'd1 == {1'b0, n_q}) state_d = ST_ITEM;
        else state_d = ST_PT;
      end
      ST_ITEM: begin
        mul_a   = {1'b0, sat32({19'b0, sum_d_q})};
        mul_b   = {1'b0, sat32({19'b0, sum_d_q})};
        state_d = ST_ACC;
      end
      ST_ACC: state_d = last_q ? ST_MD : ST_DONE;
      ST_MD: begin
        div_ctl = '{start: 1'b1, iters: IT_FULL};
        div_dvd = 64'(err_sum_q);
        div_dsr = DIV_W'(cnt_div);
        state_d = ST_MW;
      end
      ST_MW: if (div_done) state_d = ST_MM;
      ST_MM: begin
        mul_a   = {1'b0, mean_o_q};
        mul_b   = {1'b0, mean_o_q};
        state_d = ST_VD;
      end
      ST_VD: begin
        div_ctl = '{start: 1'b1, iters: IT_FULL};
        div_dvd = err_sq_q;
        div_dsr = DIV_W'(cnt_div);
        state_d = ST_VW;
      end
      ST_VW: if (div_done) state_d = ST_SQ;
      ST_SQ: if (sq_i_q == 5'd0) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {33'b0, mul_a} * {33'b0, mul_b};
  end

  // run statistics and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= PC_RESET;
      err_sum_q <= '0;
      err_sq_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      if (state_q == ST_ACC && cnt_q < CNT_MAX) begin
        err_sum_q <= err_sum_q + SUM_W'(ad_q);
        err_sq_q  <= (err_sq_q > ~{16'b0, prod_q[63:16]}) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : err_sq_q + {16'b0, prod_q[63:16]};
        cnt_q     <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_DONE && out_free && last_q) begin
        err_sum_q <= '0;
        err_sq_q  <= '0;
        cnt_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mean_a_q <= mean_a_i;
          mean_b_q <= mean_b_i;
          sd_a_q   <= (sd_a_i == 32'd0) ? 32'd1 : sd_a_i;
          sd_b_q   <= (sd_b_i == 32'd0) ? 32'd1 : sd_b_i;
          last_q   <= last_i;
          n_q      <= (pc_q == 8'd0) ? 8'd1 : pc_q;
        end
      end
      ST_RANGE: begin
        lo_q   <= lo_w;
        span_q <= 36'(hi_w - lo_w);
        sel_q  <= 1'b0;
      end
      ST_NW: begin
        qstep_q <= div_quo[35:0];
        rstep_q <= div_rem[7:0];
        qacc_q  <= '0;
        racc_q  <= '0;
        k_q     <= '0;
        sum_d_q <= '0;
        sum_a_q <= '0;
        sum_b_q <= '0;
      end
      ST_CW: begin
        if (div_done) begin
          if (sel_q) c_b_q <= div_quo[59:0];
          else c_a_q <= div_quo[59:0];
          sel_q <= !sel_q;
        end
      end
      ST_PT: if (far_w) t_q <= '0;
      ST_ZW: if (div_done) z_q <= div_quo[19:0];
      ST_QW: begin
        if (div_done) begin
          t_q  <= '0;
          sh_q <= div_quo[4:0];
          r_q  <= div_rem[31:0];
          p_q  <= 33'h1_0000_0000;
          hk_q <= EXP_TERMS;
        end
      end
      ST_H2: v_q <= prod_q[63:32];
      ST_H3: begin
        p_q  <= 33'h1_0000_0000 - {1'b0, qv_w};
        hk_q <= hk_q - 4'd1;
      end
      ST_M:  m_q <= prod_q[62:32];
      ST_C2: p1_q <= prod_q[62:0];
      ST_C3: begin
        if (p2_w[58:32] != 27'd0 || s_w >= TERM_CAP) t_q <= TERM_CAP;
        else t_q <= s_w;
      end
      ST_TERM: begin
        if (!sel_q) begin
          ta_q  <= t_q;
          sel_q <= 1'b1;
        end else begin
          sel_q   <= 1'b0;
          sum_d_q <= sum_d_q + 45'((ta_q > t_q) ? ta_q - t_q : t_q - ta_q);
          sum_a_q <= sum_a_q + 45'(ta_q);
          sum_b_q <= sum_b_q + 45'(t_q);
          k_q     <= k_q + 8'd1;
          // step x by span/n, carrying the remainder
          if ({1'b0, racc_q} + {1'b0, rstep_q} >= {1'b0, n_q}) begin
            racc_q <= 8'({1'b0, racc_q} + {1'b0, rstep_q} - {1'b0, n_q});
            qacc_q <= qacc_q + qstep_q + 36'd1;
          end else begin
            racc_q <= racc_q + rstep_q;
            qacc_q <= qacc_q + qstep_q;
          end
        end
      end
      ST_ITEM: begin
        ad_q     <= sat32({19'b0, sum_d_q});
        mean_o_q <= '0;
        sq_res_q <= '0;
      end
      ST_MW: if (div_done) mean_o_q <= sat32(div_quo);
      ST_VD: msq_q <= prod_q[63:16];
      ST_VW: begin
        if (div_done) begin
          sq_v_q   <= {varc_w, 16'b0};
          sq_res_q <= '0;
          sq_i_q   <= 5'd31;
        end
      end
      ST_SQ: begin
        if (sq_v_q >= sq_sum) begin
          sq_v_q   <= sq_v_q - sq_sum;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_i_q <= sq_i_q - 5'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          o_diff_q <= ad_q;
          o_a_q    <= sat32({19'b0, sum_a_q});
          o_b_q    <= sat32({19'b0, sum_b_q});
          o_mean_q <= mean_o_q;
          o_sd_q   <= sat32(sq_res_q);
          o_stat_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign area_diff_o   = o_diff_q;
  assign area_a_o      = o_a_q;
  assign area_b_o      = o_b_q;
  assign err_mean_o    = o_mean_q;
  assign err_stddev_o  = o_sd_q;
  assign stats_valid_o = o_stat_q;

endmodule

[hw/rtl/gpad_checker.sv]
// ----------------------------------------------------------------------------
// gpad_checker
// Port-level checks for the Gaussian pair area difference block.
// ----------------------------------------------------------------------------
module gpad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] area_diff_o,
  input logic [31:0] err_mean_o,
  input logic [31:0] err_stddev_o,
  input logic        stats_valid_o
);

  // one beat in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a beat while not going busy");

  // stats fields are zero on a beat without stats
  a_stats_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stats_valid_o |-> err_mean_o == 32'd0 && err_stddev_o == 32'd0)
    else $error("statistics present without stats_valid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(area_diff_o))
    else $error("stalled result changed");

endmodule

bind gaussian_pair_area_difference gpad_checker u_gpad_checker (.*);

[tb/tb_gaussian_pair_area_difference.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_pair_area_difference
// Self-checking bench: random and directed Gaussian pairs are fed through a
// valid/stall driver, and every output beat is compared against a local
// fixed-point model of the Riemann sums and of the run statistics.
// ----------------------------------------------------------------------------
module tb_gaussian_pair_area_difference;
  import gpad_pkg::*;

  localparam int unsigned MAX_RUN = 1024;
  localparam int unsigned LONG_RUN = 80;
  localparam int unsigned STALL_LIMIT = 150000;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] Z_LIMIT = 64'h10_0000;

  typedef struct {
    logic [31:0] mean_a;
    logic [31:0] sd_a;
    logic [31:0] mean_b;
    logic [31:0] sd_b;
    logic        last;
  } pair_t;

  typedef struct {
    logic [31:0] area_diff;
    logic [31:0] area_a;
    logic [31:0] area_b;
    logic [31:0] err_mean;
    logic [31:0] err_stddev;
    logic        stats_valid;
  } areas_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] mean_a_i = '0;
  logic [31:0] sd_a_i = '0;
  logic [31:0] mean_b_i = '0;
  logic [31:0] sd_b_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] area_diff_o, area_a_o, area_b_o, err_mean_o, err_stddev_o;
  logic        stats_valid_o;

  gaussian_pair_area_difference #(.MAX_ITEMS(MAX_RUN)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .mean_a_i, .sd_a_i, .mean_b_i, .sd_b_i, .last_i, .out_valid_o,
    .out_stall_i, .area_diff_o, .area_a_o, .area_b_o, .err_mean_o,
    .err_stddev_o, .stats_valid_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pair_t  pending_pairs[$];
  areas_t expected_areas[$];
  pair_t  driven_pair;
  int     errors = 0;
  bit     calm = 1'b0;
  int     stall_cycles = 0;

  // model state
  logic [7:0]  points_reg = PC_RESET;
  logic [63:0] run_err_sum = '0;
  logic [63:0] run_sq_sum = '0;
  int unsigned run_count = 0;

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'h4000_0000_0000_0000;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // step-weighted density sample, Q9.28, capped
  function automatic logic [63:0] density_q28(longint x, longint mu, longint sd,
                                              longint coef);
    longint      offs;
    logic [63:0] z, t, q, r, p, e, m;
    logic [127:0] prod;
    offs = x - mu;
    if (offs < 0) offs = -offs;
    z = 64'(offs <<< 16) / 64'(sd);
    if (z >= Z_LIMIT) return '0;
    t = (z * z) >> 1;
    q = t / 64'(LN2_Q32);
    if (q >= 32) return '0;
    r = t - q * 64'(LN2_Q32);
    p = ONE_Q32;
    for (int k = EXP_TERMS; k >= 1; k--) p = ONE_Q32 - ((r * p) >> 32) / 64'(k);
    e = p >> q;
    m = (e * 64'(INV_SQRT2PI)) >> 32;
    prod = (128'(coef) * 128'(m)) >> 28;
    return (prod > 128'(TERM_CAP)) ? 64'(TERM_CAP) : prod[63:0];
  endfunction

  function automatic areas_t predict_areas(pair_t pr);
    areas_t      res;
    longint      ma, mb, sa, sb, n, lo, hi, span, ca, cb, x;
    logic [63:0] ta, tb, sum_d, sum_a, sum_b, sq, cnt, msq, var_v;
    logic [64:0] wide;
    ma = longint'($signed(pr.mean_a));
    mb = longint'($signed(pr.mean_b));
    sa = (pr.sd_a == 0) ? 1 : longint'({32'd0, pr.sd_a});
    sb = (pr.sd_b == 0) ? 1 : longint'({32'd0, pr.sd_b});
    n = (points_reg == 0) ? 1 : longint'(points_reg);
    lo = (ma - 4 * sa < mb - 4 * sb) ? ma - 4 * sa : mb - 4 * sb;
    hi = (ma + 4 * sa > mb + 4 * sb) ? ma + 4 * sa : mb + 4 * sb;
    span = hi - lo;
    ca = (span <<< 24) / (n * sa);
    cb = (span <<< 24) / (n * sb);
    sum_d = '0;
    sum_a = '0;
    sum_b = '0;
    for (longint k = 0; k < n; k++) begin
      x = lo + (k * span) / n;
      ta = density_q28(x, ma, sa, ca);
      tb = density_q28(x, mb, sb, cb);
      sum_d += (ta > tb) ? ta - tb : tb - ta;
      sum_a += ta;
      sum_b += tb;
    end
    res.area_diff = clip32(sum_d);
    res.area_a = clip32(sum_a);
    res.area_b = clip32(sum_b);
    res.err_mean = '0;
    res.err_stddev = '0;
    res.stats_valid = pr.last;
    if (run_count < MAX_RUN) begin
      sq = (64'(res.area_diff) * 64'(res.area_diff)) >> 16;
      run_err_sum += 64'(res.area_diff);
      wide = 65'(run_sq_sum) + 65'(sq);
      run_sq_sum = wide[64] ? '1 : wide[63:0];
      run_count++;
    end
    if (pr.last) begin
      cnt = (run_count == 0) ? 1 : 64'(run_count);
      res.err_mean = clip32(run_err_sum / cnt);
      msq = (64'(res.err_mean) * 64'(res.err_mean)) >> 16;
      var_v = run_sq_sum / cnt;
      var_v = (var_v > msq) ? var_v - msq : '0;
      if (var_v > 64'(VAR_CAP)) var_v = 64'(VAR_CAP);
      res.err_stddev = clip32(int_sqrt(var_v << 16));
      run_err_sum = '0;
      run_sq_sum = '0;
      run_count = 0;
    end
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_areas = {expected_areas, predict_areas(driven_pair)};
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
          driven_pair = pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          mean_a_i <= driven_pair.mean_a;
          sd_a_i <= driven_pair.sd_a;
          mean_b_i <= driven_pair.mean_b;
          sd_b_i <= driven_pair.sd_b;
          last_i <= driven_pair.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    areas_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_areas.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got area_diff %h", $time,
                   area_diff_o);
          errors++;
        end else begin
          want = expected_areas.pop_front();
          check_field("area_diff", want.area_diff, area_diff_o);
          check_field("area_a", want.area_a, area_a_o);
          check_field("area_b", want.area_b, area_b_o);
          check_field("err_mean", want.err_mean, err_mean_o);
          check_field("err_stddev", want.err_stddev, err_stddev_o);
          check_field("stats_valid", 32'(want.stats_valid), 32'(stats_valid_o));
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 22);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic pair_t rand_pair(int last_pct);
    pair_t pr;
    case ($urandom_range(9))
      0: begin
        pr.mean_a = $urandom;
        pr.mean_b = $urandom;
        pr.sd_a = $urandom;
        pr.sd_b = $urandom;
      end
      1: begin
        pr.mean_a = $urandom;
        pr.mean_b = pr.mean_a + $urandom_range(65535);
        pr.sd_a = $urandom_range(3);
        pr.sd_b = $urandom_range(1 << 20);
      end
      default: begin
        pr.mean_a = 32'($signed($urandom_range(1 << 20)) - (1 <<< 19));
        pr.mean_b = 32'($signed($urandom_range(1 << 20)) - (1 <<< 19));
        pr.sd_a = $urandom_range(1 << 18, 1 << 12);
        pr.sd_b = $urandom_range(1 << 18, 1 << 12);
      end
    endcase
    pr.last = ($urandom_range(99) < last_pct);
    return pr;
  endfunction

  task automatic queue_pair(pair_t pr);
    pending_pairs = {pending_pairs, pr};
  endtask

  task automatic add_pair(logic [31:0] ma, logic [31:0] sa, logic [31:0] mb,
                          logic [31:0] sb, logic lst);
    pair_t pr;
    pr.mean_a = ma;
    pr.sd_a = sa;
    pr.mean_b = mb;
    pr.sd_b = sb;
    pr.last = lst;
    queue_pair(pr);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid_i || expected_areas.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic write_points(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    points_reg = v;
  endtask

  initial begin
    pair_t pr;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset point count
    add_pair(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    add_pair(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0);
    add_pair(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 1'b1);
    add_pair(32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 32'h0004_0000, 1'b1);
    add_pair(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    add_pair(32'h0000_0000, 32'h0001_0000, 32'h0100_0000, 32'h0001_0000, 1'b0);
    add_pair(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    drain();

    write_points(8'd255);
    add_pair(32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_C000, 1'b0);
    add_pair(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0001_0000, 1'b1);
    drain();

    write_points(8'd0);
    for (int i = 0; i < 10; i++) queue_pair(rand_pair(20));
    drain();

    // long run with the sender free-running
    write_points(8'd1);
    calm = 1'b1;
    for (int i = 0; i < LONG_RUN; i++) begin
      pr = rand_pair(0);
      pr.last = (i == LONG_RUN - 1);
      queue_pair(pr);
    end
    drain();
    calm = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      write_points((ph == 4) ? 8'($urandom_range(40, 20)) : 8'($urandom_range(12, 1)));
      for (int i = 0; i < 100; i++) queue_pair(rand_pair(12));
      drain();
    end

    repeat (500) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
